FILE: rtl/core/bdq_pkg.sv
// Command and status codes shared by the bounded deque block.
package bdq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_UPDATE     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned DataW = 32;

endpackage

FILE: rtl/core/bounded_deque_with_update_top.sv
// Double-ended queue on a ring memory, with a sequenced match-and-replace walk.
//
// Usage: a command transaction (cmd, value, new_value) is taken on the input
// channel when in_valid and in_ready are both high. in_ready is high only
// while the block is idle, so one command is in flight at a time. Each
// command yields exactly one result transaction (status, front_value,
// back_value, entry_count) that describes the queue after the command.
// Push, pop and unused codes execute in S_EXEC and then read the front and
// back entries back from the ring memory through S_FETCH, S_FETCH_B and
// S_LAST before out_valid rises; S_FETCH_B and S_LAST are skipped, and both
// values are reported as zero, when the queue is left empty. The update
// command walks the stored entries front to back in S_UPD, one memory read
// per cycle with the compare and rewrite of the previous entry overlapped,
// and then reads the front and back entries in the same way. A new command
// is taken only after the result transaction of the last one has completed
// and the block is back in S_IDLE.
// A stalled receiver holds the block in its result state, out_valid high, and
// no new command is taken until then. Reset clears the head pointer and the
// count, giving an empty queue; the ring memory itself is not cleared.
module bounded_deque_with_update_top
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       cmd,
  input  logic signed [DataW-1:0]          value,
  input  logic signed [DataW-1:0]          new_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic signed [DataW-1:0]          front_value,
  output logic signed [DataW-1:0]          back_value,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UPD,
    S_FETCH,
    S_FETCH_B,
    S_LAST,
    S_RESP
  } state_t;

  state_t             state;
  logic [2:0]         cmd_reg;
  logic [DataW-1:0]   match_value;
  logic [DataW-1:0]   repl_value;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CW-1:0]      walk_cnt;
  logic [AW-1:0]      walk_slot;
  logic               pend;
  logic [AW-1:0]      pend_slot;

  logic [DataW-1:0]   mem [DEPTH];
  logic [DataW-1:0]   rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DataW-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic [AW-1:0]      head_dec;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      walk_inc;
  logic [AW-1:0]      tail_slot;
  logic [AW-1:0]      last_slot;
  logic [CW-1:0]      count_dec;
  logic               is_full;
  logic               is_empty;
  logic               walk_issue;

  // Ring addition of two in-range offsets.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  assign head_dec   = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc   = ring_inc(head);
  assign walk_inc   = ring_inc(walk_slot);
  assign tail_slot  = ring_add(head, count[AW-1:0]);
  assign count_dec  = count - CW'(1);
  assign last_slot  = ring_add(head, count_dec[AW-1:0]);
  assign is_full    = (count == CW'(DEPTH));
  assign is_empty   = (count == '0);
  assign walk_issue = (walk_cnt != count);

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_RESP);
  assign entry_count = count;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head_dec;
    mem_wdata = match_value;
    mem_raddr = walk_slot;
    unique case (state)
      S_EXEC: begin
        if (cmd_reg == CMD_PUSH_FRONT && !is_full) begin
          mem_we    = 1'b1;
          mem_waddr = head_dec;
        end else if (cmd_reg == CMD_PUSH_BACK && !is_full) begin
          mem_we    = 1'b1;
          mem_waddr = tail_slot;
        end
      end
      S_UPD: begin
        // rd_data holds the entry read in the previous cycle.
        if (pend && rd_data == match_value) begin
          mem_we    = 1'b1;
          mem_waddr = pend_slot;
          mem_wdata = repl_value;
        end
        mem_raddr = walk_slot;
      end
      S_FETCH:   mem_raddr = head;
      S_FETCH_B: mem_raddr = last_slot;
      default:   mem_raddr = walk_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_reg     <= cmd;
            match_value <= value;
            repl_value  <= new_value;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= ST_DONE;
          state  <= S_FETCH;
          case (cmd_reg)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status <= ST_FULL;
              end else begin
                head  <= head_dec;
                count <= count + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                status <= ST_FULL;
              end else begin
                count <= count + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                status <= ST_EMPTY;
              end else begin
                head  <= head_inc;
                count <= count_dec;
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                status <= ST_EMPTY;
              end else begin
                count <= count_dec;
              end
            end
            CMD_UPDATE: begin
              walk_cnt  <= '0;
              walk_slot <= head;
              pend      <= 1'b0;
              state     <= S_UPD;
            end
            default: ;
          endcase
        end
        S_UPD: begin
          // Read one entry per cycle; the compare and write of the previous
          // entry happen in the same cycle through the memory control above.
          if (walk_issue) begin
            walk_cnt  <= walk_cnt + CW'(1);
            walk_slot <= walk_inc;
            pend      <= 1'b1;
            pend_slot <= walk_slot;
          end else begin
            pend  <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (is_empty) begin
            front_value <= '0;
            back_value  <= '0;
            state       <= S_RESP;
          end else begin
            state <= S_FETCH_B;
          end
        end
        S_FETCH_B: begin
          front_value <= rd_data;
          state       <= S_LAST;
        end
        S_LAST: begin
          back_value <= rd_data;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the bounded deque with match-and-replace update.
module testbench;
  import bdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT = 23;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;

  typedef struct packed {
    status_t                status;
    logic signed [31:0]     front;
    logic signed [31:0]     back;
    logic [CNT_W-1:0]       count;
  } deque_view_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [2:0] cmd;
  logic signed [DataW-1:0] value;
  logic signed [DataW-1:0] new_value;
  logic out_valid;
  logic out_ready;
  logic [1:0] status;
  logic signed [DataW-1:0] front_value;
  logic signed [DataW-1:0] back_value;
  logic [CNT_W-1:0] entry_count;

  // Shadow copy of the queue contents, advanced as each command is accepted.
  logic signed [31:0] model_ring [DEPTH];
  logic [IDX_W-1:0] model_head;
  logic [CNT_W-1:0] model_count;

  deque_view_t expected_views[$];
  int mismatches;
  int cycle_count;
  int hold_cycles;
  bit steady;

  bounded_deque_with_update_top #(.DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .value       (value),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] ring_slot(input logic [CNT_W-1:0] offset);
    return model_head + offset[IDX_W-1:0];
  endfunction

  function automatic deque_view_t deque_apply(input logic [2:0] c,
                                              input logic signed [31:0] v,
                                              input logic signed [31:0] nv);
    deque_view_t view;
    view.status = ST_DONE;
    view.front = '0;
    view.back = '0;
    case (c)
      CMD_PUSH_FRONT: begin
        if (model_count == DEPTH) begin
          view.status = ST_FULL;
        end else begin
          model_head = model_head - 1'b1;
          model_ring[model_head] = v;
          model_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (model_count == DEPTH) begin
          view.status = ST_FULL;
        end else begin
          model_ring[ring_slot(model_count)] = v;
          model_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (model_count == 0) begin
          view.status = ST_EMPTY;
        end else begin
          model_head = model_head + 1'b1;
          model_count--;
        end
      end
      CMD_POP_BACK: begin
        if (model_count == 0) view.status = ST_EMPTY;
        else model_count--;
      end
      CMD_UPDATE: begin
        for (int i = 0; i < model_count; i++) begin
          if (model_ring[ring_slot(CNT_W'(i))] == v) model_ring[ring_slot(CNT_W'(i))] = nv;
        end
      end
      default: ;
    endcase
    if (model_count != 0) begin
      view.front = model_ring[ring_slot('0)];
      view.back = model_ring[ring_slot(model_count - 1'b1)];
    end
    view.count = model_count;
    return view;
  endfunction

  function automatic logic signed [31:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      case ($urandom_range(3))
        0: return 32'sd0;
        1: return 32'sd1;
        2: return -32'sd1;
        default: return 32'sd42;
      endcase
    end
    if (r < 50) return $urandom_range(1) ? MOST_POS : MOST_NEG;
    return $urandom();
  endfunction

  // Offers one command and waits until it is taken; valid stays high after
  // the transaction until the next call or the end of the stimulus.
  task automatic send_cmd(input logic [2:0] c, input logic signed [31:0] v,
                          input logic signed [31:0] nv);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    value <= v;
    new_value <= nv;
    do @(posedge clk); while (!in_ready);
    expected_views.push_back(deque_apply(c, v, nv));
  endtask

  task automatic test_empty_queue();
    send_cmd(CMD_POP_FRONT, 32'sd3, 32'sd0);
    send_cmd(CMD_POP_BACK, 32'sd3, 32'sd0);
    send_cmd(CMD_UPDATE, 32'sd0, 32'sd9);
    send_cmd(CMD_UNUSED_LO, MOST_NEG, MOST_POS);
    send_cmd(CMD_UNUSED_HI, MOST_POS, MOST_NEG);
  endtask

  // The first front push wraps the head pointer below slot zero.
  task automatic test_extremes_and_wrap();
    send_cmd(CMD_PUSH_FRONT, MOST_POS, 32'sd0);
    send_cmd(CMD_PUSH_BACK, MOST_NEG, 32'sd0);
    send_cmd(CMD_PUSH_FRONT, 32'sd0, 32'sd0);
    send_cmd(CMD_PUSH_BACK, -32'sd1, 32'sd0);
    send_cmd(CMD_UPDATE, -32'sd1, MOST_POS);
    send_cmd(CMD_UPDATE, MOST_POS, MOST_NEG);
    send_cmd(CMD_POP_BACK, 32'sd0, 32'sd0);
    send_cmd(CMD_POP_FRONT, 32'sd0, 32'sd0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < 14; i++) begin
      send_cmd((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 32'(i * 3 - 7), 32'sd0);
    end
    send_cmd(CMD_PUSH_FRONT, 32'sd77, 32'sd0);
    send_cmd(CMD_PUSH_BACK, 32'sd78, 32'sd0);
    send_cmd(CMD_UPDATE, MOST_NEG, -32'sd5);
  endtask

  // The receiver stops for a long stretch while commands keep coming.
  task automatic test_output_stall();
    hold_cycles = 300;
    repeat (6) send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_POP_FRONT,
                        pick_data(), pick_data());
  endtask

  task automatic test_random_traffic(input int n_items);
    int push_pct;
    int r;
    logic [2:0] c;
    logic signed [31:0] v;
    logic signed [31:0] nv;
    push_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      // Swing between filling and draining so both full and empty are hit.
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      steady = (k >= n_items / 3) && (k < n_items / 3 + 250);
      r = $urandom_range(99);
      if (r < 3) c = CMD_UNUSED_LO + 3'($urandom_range(2));
      else if (r < 15) c = CMD_UPDATE;
      else if ($urandom_range(99) < push_pct)
        c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      v = pick_data();
      nv = pick_data();
      if (c == CMD_UPDATE && model_count != 0 && $urandom_range(99) < 60) begin
        v = model_ring[ring_slot(CNT_W'($urandom_range(model_count - 1)))];
      end
      send_cmd(c, v, nv);
    end
    steady = 1'b0;
  endtask

  // Receiver side: out_ready changes at the falling edge only.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    deque_view_t exp_view;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result transaction: status=%0d front=%0d back=%0d count=%0d",
                     status, front_value, back_value, entry_count);
          mismatches++;
        end else begin
          exp_view = expected_views.pop_front();
          if (status != exp_view.status || front_value != exp_view.front ||
              back_value != exp_view.back || entry_count != exp_view.count) begin
            if (mismatches < MAX_REPORTS)
              $display("result mismatch: expected status=%0d front=%0d back=%0d count=%0d, %s",
                       exp_view.status, exp_view.front, exp_view.back, exp_view.count,
                       $sformatf("got status=%0d front=%0d back=%0d count=%0d",
                                 status, front_value, back_value, entry_count));
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    value = '0;
    new_value = '0;
    mismatches = 0;
    hold_cycles = 0;
    steady = 1'b0;
    model_head = '0;
    model_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_extremes_and_wrap();
    test_full_queue();
    test_output_stall();
    test_random_traffic(1620);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bdq_pkg.sv
rtl/core/bounded_deque_with_update_top.sv
sim/testbench.sv
